// ===== src/hann_windowed_fft_magnitude_core_defines.svh =====
// assertion macros for the windowed fft magnitude core
`ifndef HANN_WINDOWED_FFT_MAGNITUDE_CORE_DEFINES_SVH
`define HANN_WINDOWED_FFT_MAGNITUDE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HWFM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define HWFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HWFM_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HWFM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/hwfm_pkg.sv =====
// shared constants and coefficient functions for the windowed fft magnitude core
package hwfm_pkg;

    localparam int FFT_POINTS_DEF   = 256;
    localparam int BINS_EMITTED_DEF = 30;
    localparam int SAMPLE_W         = 12;
    localparam int BIN_W            = 8;
    localparam int MAG_W            = 17;
    localparam int CFG_W            = 3;
    localparam int COEF_W           = 17;
    localparam logic [MAG_W-1:0] MAG_MAX = 17'h1FFFF;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint          ONE_Q30     = 64'sd1073741824;
    localparam logic [31:0]     QUARTER_TURN = 32'h4000_0000;

    // taylor cosine over one quadrant, q30 internally, q1.15 out (0..32768)
    function automatic logic signed [COEF_W-1:0] quad_cos(input logic [31:0] q);
        longint x;
        longint x2;
        longint t;
        x  = longint'((64'(q) * HALF_PI_Q30) >> 30);
        x2 = (x * x) >>> 30;
        t  = ONE_Q30 - x2 / 56;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 30;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 12;
        t  = ONE_Q30 - ((x2 * t) >>> 30) / 2;
        if (t < 0) t = 0;
        if (t > ONE_Q30) t = ONE_Q30;
        return COEF_W'((t + 64'sd16384) >>> 15);
    endfunction

    function automatic logic signed [COEF_W-1:0] cos_q15(input logic [31:0] p);
        logic [31:0] q;
        q = {2'b00, p[29:0]};
        unique case (p[31:30])
            2'd0:    return quad_cos(q);
            2'd1:    return -quad_cos(QUARTER_TURN - q);
            2'd2:    return -quad_cos(q);
            default: return quad_cos(QUARTER_TURN - q);
        endcase
    endfunction

    // hann coefficient (32768 - cos) / 2, range 0..32768
    function automatic logic [COEF_W-1:0] win_coef(input logic [31:0] p);
        logic signed [COEF_W-1:0] c;
        c = cos_q15(p);
        return COEF_W'((18'sd32768 - 18'(c)) >>> 1);
    endfunction

endpackage

// ===== src/hann_windowed_fft_magnitude_core.sv =====
// capture: one cycle per sample transaction; the frame runs on the last sample
// window pass over the N samples, then radix-2 butterflies on the shared multiplier:
// (N/2)*log2(N) butterflies in all, each a read, four products and two writes
// each emitted bin: squares, then a 32-step root, then the output wait
// input is not ready from the last sample until the last bin transaction completes
// synchronous active-low reset clears control state; the sample and work rams are not cleared
`include "hann_windowed_fft_magnitude_core_defines.svh"
module hann_windowed_fft_magnitude_core
    import hwfm_pkg::*;
#(
    parameter int FFT_POINTS   = FFT_POINTS_DEF,
    parameter int BINS_EMITTED = BINS_EMITTED_DEF
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [15:0]      s_axis_tdata,   // [11:0] sample
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] bin_index, [24:8] magnitude_x10
    output logic             m_axis_tlast
);

    localparam int LG    = $clog2(FFT_POINTS);
    localparam int SUM_W = SAMPLE_W + LG;
    localparam int SW    = $clog2(LG);
    localparam int JW    = (BINS_EMITTED > 1) ? $clog2(BINS_EMITTED) : 1;

    typedef enum logic [18:0] {
        S_CAP   = 19'h00001,
        S_WRD   = 19'h00002,
        S_WCTR  = 19'h00004,
        S_WMUL  = 19'h00008,
        S_WWR   = 19'h00010,
        S_BRD   = 19'h00020,
        S_BM0   = 19'h00040,
        S_BM1   = 19'h00080,
        S_BM2   = 19'h00100,
        S_BM3   = 19'h00200,
        S_BM4   = 19'h00400,
        S_BWB   = 19'h00800,
        S_BWA   = 19'h01000,
        S_ERD   = 19'h02000,
        S_ESQ0  = 19'h04000,
        S_ESQ1  = 19'h08000,
        S_ESQ2  = 19'h10000,
        S_ESQRT = 19'h20000,
        S_EOUT  = 19'h40000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0]     r_group;
    logic [LG-1:0]        r_cnt;
    logic [SUM_W-1:0]     r_sum;
    logic [LG-1:0]        r_idx;
    logic signed [SUM_W:0] r_x;
    logic [LG-2:0]        r_bf;
    logic [SW-1:0]        r_stage;
    logic [LG-1:0]        r_bin;
    logic [JW-1:0]        r_j;
    logic signed [63:0]   r_tr;
    logic signed [63:0]   r_ti;
    logic [63:0]          r_sq;
    logic                 r_out_valid;
    logic [BIN_W-1:0]     r_out_bin;
    logic [MAG_W-1:0]     r_out_mag;
    logic                 r_out_last;

    logic [SAMPLE_W-1:0]  r_samp_mem [FFT_POINTS];
    logic [SAMPLE_W-1:0]  r_samp_rd;
    logic [63:0]          r_work [FFT_POINTS];
    logic [63:0]          r_rd_a;
    logic [63:0]          r_rd_b;

    // handshakes
    logic w_in_acc;
    logic w_out_acc;
    assign s_axis_tready = (r_state == S_CAP);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign w_out_acc     = r_out_valid && m_axis_tready;
    assign m_axis_tdata  = {7'd0, r_out_mag, r_out_bin};
    assign m_axis_tlast  = r_out_last;

    // butterfly addressing: insert a zero at bit position stage
    logic [LG-1:0] w_bfx;
    logic [LG-1:0] w_lo_mask;
    logic [LG-1:0] w_addr_a;
    logic [LG-1:0] w_addr_b;
    logic [LG-2:0] w_tw_full;
    logic [LG-1:0] w_rev;

    assign w_bfx     = {1'b0, r_bf};
    assign w_lo_mask = (LG'(1) << r_stage) - LG'(1);
    assign w_addr_a  = ((w_bfx >> r_stage) << (32'(r_stage) + 1)) | (w_bfx & w_lo_mask);
    assign w_addr_b  = w_addr_a | (LG'(1) << r_stage);
    assign w_tw_full = (LG-1)'((w_bfx & w_lo_mask) << (LG - 1 - 32'(r_stage)));

    always_comb begin
        for (int b = 0; b < LG; b++) begin
            w_rev[b] = r_idx[LG-1-b];
        end
    end

    // coefficient roms
    logic [COEF_W-1:0]        w_win;
    logic signed [COEF_W-1:0] w_cos;
    logic signed [COEF_W-1:0] w_sin;

    hwfm_tables #(
        .FFT_POINTS(FFT_POINTS)
    ) u_tables (
        .i_clk     (i_clk),
        .i_win_idx (r_idx),
        .i_tw_idx  (w_tw_full),
        .o_win     (w_win),
        .o_cos     (w_cos),
        .o_sin     (w_sin)
    );

    // operands from work ram
    logic signed [31:0] w_ar;
    logic signed [31:0] w_ai;
    logic signed [31:0] w_br;
    logic signed [31:0] w_bi;
    logic signed [31:0] w_tr32;
    logic signed [31:0] w_ti32;
    assign w_ar   = r_rd_a[63:32];
    assign w_ai   = r_rd_a[31:0];
    assign w_br   = r_rd_b[63:32];
    assign w_bi   = r_rd_b[31:0];
    assign w_tr32 = r_tr[46:15];
    assign w_ti32 = r_ti[46:15];

    // shared multiplier
    logic signed [31:0] w_mul_a;
    logic signed [31:0] w_mul_b;
    logic signed [63:0] w_prod;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_WMUL: begin
                w_mul_a = 32'(r_x);
                w_mul_b = {15'd0, w_win};
            end
            S_BM0: begin
                w_mul_a = w_br;
                w_mul_b = 32'(w_cos);
            end
            S_BM1: begin
                w_mul_a = w_bi;
                w_mul_b = 32'(w_sin);
            end
            S_BM2: begin
                w_mul_a = w_bi;
                w_mul_b = 32'(w_cos);
            end
            S_BM3: begin
                w_mul_a = w_br;
                w_mul_b = 32'(w_sin);
            end
            S_ESQ0: begin
                w_mul_a = w_ar;
                w_mul_b = w_ar;
            end
            S_ESQ1: begin
                w_mul_a = w_ai;
                w_mul_b = w_ai;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    hwfm_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // root unit
    logic        w_sqrt_start;
    logic        w_sqrt_done;
    logic [31:0] w_root;
    assign w_sqrt_start = (r_state == S_ESQ2);

    hwfm_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_value (r_sq + $unsigned(w_prod)),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // output scaling: times ten, then divide by 4N (bin 0 by 4N*N)
    logic [35:0]      w_m10;
    logic [35:0]      w_scaled;
    logic [MAG_W-1:0] w_mag;
    assign w_m10    = 36'(w_root) * 36'd10;
    assign w_scaled = (r_bin == '0) ? (w_m10 >> (2 * LG + 2)) : (w_m10 >> (LG + 2));
    assign w_mag    = (w_scaled > 36'(MAG_MAX)) ? MAG_MAX : w_scaled[MAG_W-1:0];

    // frame centering: floor(16*(s*N - sum)/N)
    logic signed [SUM_W:0] w_d;
    assign w_d = $signed({1'b0, SUM_W'(r_samp_rd) << LG}) - $signed({1'b0, r_sum});

    logic [15:0] w_base;
    assign w_base = 16'(BINS_EMITTED) * 16'(r_group);

    // work ram ports
    logic          w_rd_en;
    logic [LG-1:0] w_rd_addr_a;
    logic          w_wr_en;
    logic [LG-1:0] w_wr_addr;
    logic [63:0]   w_wr_data;

    assign w_rd_en     = (r_state == S_BRD) || (r_state == S_ERD);
    assign w_rd_addr_a = (r_state == S_ERD) ? r_bin : w_addr_a;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_addr_a;
        w_wr_data = {w_ar + w_tr32, w_ai + w_ti32};
        priority if (r_state == S_WWR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_rev;
            w_wr_data = {w_prod[46:15], 32'd0};
        end else if (r_state == S_BWB) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_addr_b;
            w_wr_data = {w_ar - w_tr32, w_ai - w_ti32};
        end else if (r_state == S_BWA) begin
            w_wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_work[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_a <= r_work[w_rd_addr_a];
            r_rd_b <= r_work[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_samp_mem[r_cnt] <= s_axis_tdata[SAMPLE_W-1:0];
        end
        r_samp_rd <= r_samp_mem[r_idx];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CAP:   if (w_in_acc && (r_cnt == LG'(FFT_POINTS - 1))) n_state = S_WRD;
            S_WRD:   n_state = S_WCTR;
            S_WCTR:  n_state = S_WMUL;
            S_WMUL:  n_state = S_WWR;
            S_WWR:   n_state = (r_idx == LG'(FFT_POINTS - 1)) ? S_BRD : S_WRD;
            S_BRD:   n_state = S_BM0;
            S_BM0:   n_state = S_BM1;
            S_BM1:   n_state = S_BM2;
            S_BM2:   n_state = S_BM3;
            S_BM3:   n_state = S_BM4;
            S_BM4:   n_state = S_BWB;
            S_BWB:   n_state = S_BWA;
            S_BWA: begin
                if ((&r_bf) && (r_stage == SW'(LG - 1))) n_state = S_ERD;
                else n_state = S_BRD;
            end
            S_ERD:   n_state = S_ESQ0;
            S_ESQ0:  n_state = S_ESQ1;
            S_ESQ1:  n_state = S_ESQ2;
            S_ESQ2:  n_state = S_ESQRT;
            S_ESQRT: if (w_sqrt_done) n_state = S_EOUT;
            S_EOUT: begin
                if (w_out_acc) n_state = r_out_last ? S_CAP : S_ERD;
            end
            default: n_state = S_CAP;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CAP;
            r_group     <= '0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_group <= i_cfg_wr_data;
            end
            if (w_in_acc) begin
                r_cnt <= r_cnt + LG'(1);
                r_sum <= r_sum + SUM_W'(s_axis_tdata[SAMPLE_W-1:0]);
            end
            if ((r_state == S_ESQRT) && w_sqrt_done) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
                if (r_out_last) r_sum <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CAP:  r_idx <= '0;
            S_WCTR: r_x <= w_d >>> (LG - 4);
            S_WWR: begin
                r_idx   <= r_idx + LG'(1);
                r_bf    <= '0;
                r_stage <= '0;
            end
            S_BM1:  r_tr <= w_prod;
            S_BM2:  r_tr <= r_tr + w_prod;
            S_BM3:  r_ti <= w_prod;
            S_BM4:  r_ti <= r_ti - w_prod;
            S_BWA: begin
                r_bf <= r_bf + (LG-1)'(1);
                if (&r_bf) r_stage <= r_stage + SW'(1);
                r_bin <= w_base[LG-1:0];
                r_j   <= '0;
            end
            S_ESQ1: r_sq <= $unsigned(w_prod);
            S_ESQRT: begin
                r_out_bin  <= BIN_W'(r_bin);
                r_out_mag  <= w_mag;
                r_out_last <= (r_j == JW'(BINS_EMITTED - 1));
            end
            S_EOUT: begin
                if (w_out_acc) begin
                    r_bin <= r_bin + LG'(1);
                    r_j   <= r_j + JW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    `HWFM_ASSERT_IMPLY(a_no_input_while_result, s_axis_tready, !m_axis_tvalid, "input ready while a result is pending")
    `HWFM_ASSERT_NEXT(a_ready_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready, "not ready after final bin")
    `HWFM_ASSERT_IMPLY(a_root_in_wait, w_sqrt_done, r_state == S_ESQRT, "root finished outside its wait state")

endmodule

// ===== src/hwfm_mul.sv =====
// shared signed 32x32 multiplier with registered product
module hwfm_mul
    import hwfm_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== src/hwfm_isqrt.sv =====
// bit-pair integer square root of a 64-bit value, one step per cycle
module hwfm_isqrt
    import hwfm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic [63:0] w_trial;
    logic        w_ge;

    assign w_trial = r_r + r_bit;
    assign w_ge    = (r_v >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_bit == 64'd1);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == 64'd1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= 64'd0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (w_ge) begin
                r_v <= r_v - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

// ===== src/hwfm_tables.sv =====
// hann window and twiddle coefficient roms with registered reads
module hwfm_tables
    import hwfm_pkg::*;
#(
    parameter int FFT_POINTS = FFT_POINTS_DEF
)
(
    input  logic                          i_clk,
    input  logic [$clog2(FFT_POINTS)-1:0] i_win_idx,
    input  logic [$clog2(FFT_POINTS)-2:0] i_tw_idx,
    output logic [COEF_W-1:0]             o_win,
    output logic signed [COEF_W-1:0]      o_cos,
    output logic signed [COEF_W-1:0]      o_sin
);

    localparam int LG   = $clog2(FFT_POINTS);
    localparam int HALF = FFT_POINTS / 2;

    logic [COEF_W-1:0]        w_win_tab [FFT_POINTS];
    logic signed [COEF_W-1:0] w_cos_tab [HALF];
    logic signed [COEF_W-1:0] w_sin_tab [HALF];

    for (genvar gi = 0; gi < FFT_POINTS; gi++) begin : g_win
        localparam logic [63:0] PW = (64'(gi) << 32) / 64'(FFT_POINTS - 1);
        assign w_win_tab[gi] = win_coef(PW[31:0]);
    end

    for (genvar gk = 0; gk < HALF; gk++) begin : g_tw
        localparam logic [63:0] PT = 64'(gk) << (32 - LG);
        assign w_cos_tab[gk] = cos_q15(PT[31:0]);
        assign w_sin_tab[gk] = cos_q15(PT[31:0] - QUARTER_TURN);
    end

    always_ff @(posedge i_clk) begin
        o_win <= w_win_tab[i_win_idx];
        o_cos <= w_cos_tab[i_tw_idx];
        o_sin <= w_sin_tab[i_tw_idx];
    end

endmodule
